// File: rtl/cpm_pkg.sv
// Shared types and constants for the cycling power measurement parser.
`timescale 1ns / 1ps

package cpm_pkg;

  // Packet layout
  localparam int HdrLen   = 4;
  localparam int BalLen   = 1;
  localparam int TqLen    = 2;
  localparam int WheelLen = 6;
  localparam int CrankLen = 4;
  localparam int PosW     = 5;
  localparam logic [PosW-1:0] PosMax = 5'd31;

  // Flag bit positions
  localparam int FlagBal   = 0;
  localparam int FlagTq    = 2;
  localparam int FlagWheel = 4;
  localparam int FlagCrank = 5;

  // Status codes
  localparam logic StatusOk    = 1'b0;
  localparam logic StatusShort = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } cpm_in_t;

  typedef struct packed {
    logic               status;
    logic        [15:0] flags_word;
    logic signed [15:0] power_watts;
    logic        [7:0]  pedal_balance;
    logic        [15:0] torque_total;
    logic        [31:0] wheel_revs;
    logic        [15:0] wheel_event_time;
    logic        [15:0] crank_revs;
    logic        [15:0] crank_event_time;
  } cpm_out_t;

  typedef struct packed {
    logic [PosW-1:0] pos;
    logic [15:0]     flags;
    logic [15:0]     power;
    logic [7:0]      balance;
    logic [15:0]     torque;
    logic [31:0]     wheel_revs;
    logic [15:0]     wheel_time;
    logic [15:0]     crank_revs;
    logic [15:0]     crank_time;
  } cpm_state_t;

endpackage

// File: rtl/cycling_power_measurement_parser.sv
// Top level: byte-stream Cycling Power Measurement parser with a two-beat result buffer.
// A record is registered as its packet's last byte is accepted, into skid if main is held.
// Throughput: one byte per cycle while item_stall is low; field placement and record
//   assembly are one combinational pass between the parse state and the result register.
// Buffer: input continues while a record waits and stalls only when both entries are full.
// Reset (rst, synchronous): clears the parse state and empties the result buffer.
`timescale 1ns / 1ps

module cycling_power_measurement_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  cpm_pkg::cpm_in_t   item,
  output logic               result_valid,
  input  logic               result_stall,
  output cpm_pkg::cpm_out_t  result
);

  cpm_pkg::cpm_state_t state;
  cpm_pkg::cpm_state_t state_next;
  cpm_pkg::cpm_out_t   rec;
  cpm_pkg::cpm_out_t   main_rec;
  cpm_pkg::cpm_out_t   skid_rec;
  logic                main_valid;
  logic                skid_valid;
  logic                accept;
  logic                gen;
  logic                drain;

  cpm_parse_step u_step (
    .state      (state),
    .item       (item),
    .state_next (state_next),
    .rec        (rec)
  );

  assign item_stall   = skid_valid;
  assign accept       = item_valid && !item_stall;
  assign gen          = accept && item.last_byte;
  assign drain        = main_valid && !result_stall;
  assign result_valid = main_valid;
  assign result       = main_rec;

  // Advance the parse state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // Hold records in the main register, overflow into the skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (drain) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        main_valid <= gen;
      end
    end else if (main_valid) begin
      if (gen) skid_valid <= 1'b1;
    end else begin
      main_valid <= gen;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      if (skid_valid) main_rec <= skid_rec;
      else            main_rec <= rec;
    end else if (main_valid) begin
      if (gen) skid_rec <= rec;
    end else begin
      main_rec <= rec;
    end
  end

  // The skid entry is only used behind a full main register
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry valid with empty main register");

  // A final byte leaves the parser at the start of a packet
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    gen |=> (state.pos == '0 && state.flags == '0))
    else $error("parse state not cleared after final byte");

  // The position counter saturates until the packet ends
  a_pos_saturates: assert property (@(posedge clk) disable iff (rst)
    (state.pos == cpm_pkg::PosMax && !gen) |=> state.pos == cpm_pkg::PosMax)
    else $error("byte position left saturation mid-packet");

  // A clean record never reports an absent balance byte
  a_absent_balance: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.flags_word[cpm_pkg::FlagBal]) |-> result.pedal_balance == '0)
    else $error("pedal balance reported while its flag is clear");

endmodule

// File: rtl/cpm_parse_step.sv
// Per-byte field placement and record assembly for one packet byte.
`timescale 1ns / 1ps

module cpm_parse_step (
  input  cpm_pkg::cpm_state_t state,
  input  cpm_pkg::cpm_in_t    item,
  output cpm_pkg::cpm_state_t state_next,
  output cpm_pkg::cpm_out_t   rec
);

  localparam logic [4:0] HdrOff = 5'(cpm_pkg::HdrLen);

  logic [4:0]         p;
  logic [7:0]         b;
  logic [15:0]        f;
  logic [4:0]         bal_end, tq_off, tq_end, wh_off, wh_mid, wh_end, cr_off, cr_mid, cr_end;
  logic [4:0]         d_tq, d_wh, d_wt, d_cr, d_ct;
  logic [5:0]         len;
  logic               st;
  cpm_pkg::cpm_state_t upd;

  assign p = state.pos;
  assign b = item.data_byte;
  assign f = state.flags;

  // Lay out the optional fields from the flags word
  always_comb begin
    bal_end = HdrOff + 5'(cpm_pkg::BalLen);
    tq_off  = HdrOff + (f[cpm_pkg::FlagBal] ? 5'(cpm_pkg::BalLen) : 5'd0);
    tq_end  = tq_off + 5'(cpm_pkg::TqLen);
    wh_off  = tq_off + (f[cpm_pkg::FlagTq] ? 5'(cpm_pkg::TqLen) : 5'd0);
    wh_mid  = wh_off + 5'd4;
    wh_end  = wh_off + 5'(cpm_pkg::WheelLen);
    cr_off  = wh_off + (f[cpm_pkg::FlagWheel] ? 5'(cpm_pkg::WheelLen) : 5'd0);
    cr_mid  = cr_off + 5'd2;
    cr_end  = cr_off + 5'(cpm_pkg::CrankLen);
    d_tq    = p - tq_off;
    d_wh    = p - wh_off;
    d_wt    = p - wh_mid;
    d_cr    = p - cr_off;
    d_ct    = p - cr_mid;
  end

  // Drop the byte into the field lane it belongs to, advance the position
  always_comb begin
    upd = state;
    if (p != cpm_pkg::PosMax) begin
      upd.pos = p + 5'd1;
      if (p < 5'd2) begin
        upd.flags[{p[0], 3'b000} +: 8] = b;
      end else if (p < HdrOff) begin
        upd.power[{p[0], 3'b000} +: 8] = b;
      end else if (f[cpm_pkg::FlagBal] && p == HdrOff) begin
        upd.balance = b;
      end else if (f[cpm_pkg::FlagTq] && p >= tq_off && p < tq_end) begin
        upd.torque[{d_tq[0], 3'b000} +: 8] = b;
      end else if (f[cpm_pkg::FlagWheel] && p >= wh_off && p < wh_mid) begin
        upd.wheel_revs[{d_wh[1:0], 3'b000} +: 8] = b;
      end else if (f[cpm_pkg::FlagWheel] && p >= wh_mid && p < wh_end) begin
        upd.wheel_time[{d_wt[0], 3'b000} +: 8] = b;
      end else if (f[cpm_pkg::FlagCrank] && p >= cr_off && p < cr_mid) begin
        upd.crank_revs[{d_cr[0], 3'b000} +: 8] = b;
      end else if (f[cpm_pkg::FlagCrank] && p >= cr_mid && p < cr_end) begin
        upd.crank_time[{d_ct[0], 3'b000} +: 8] = b;
      end
    end
  end

  // Clear the state after the final byte
  assign state_next = item.last_byte ? '0 : upd;

  // Assemble the record; a field that does not fit stops all later ones
  always_comb begin
    len = {1'b0, p} + 6'd1;
    st  = cpm_pkg::StatusOk;
    rec = '0;
    if (len < 6'(cpm_pkg::HdrLen)) begin
      st = cpm_pkg::StatusShort;
    end else begin
      rec.flags_word  = upd.flags;
      rec.power_watts = upd.power;
      if (f[cpm_pkg::FlagBal]) begin
        if ({1'b0, bal_end} <= len) rec.pedal_balance = upd.balance;
        else st = cpm_pkg::StatusShort;
      end
      if (f[cpm_pkg::FlagTq] && st == cpm_pkg::StatusOk) begin
        if ({1'b0, tq_end} <= len) rec.torque_total = upd.torque;
        else st = cpm_pkg::StatusShort;
      end
      if (f[cpm_pkg::FlagWheel] && st == cpm_pkg::StatusOk) begin
        if ({1'b0, wh_end} <= len) begin
          rec.wheel_revs       = upd.wheel_revs;
          rec.wheel_event_time = upd.wheel_time;
        end else begin
          st = cpm_pkg::StatusShort;
        end
      end
      if (f[cpm_pkg::FlagCrank] && st == cpm_pkg::StatusOk) begin
        if ({1'b0, cr_end} <= len) begin
          rec.crank_revs       = upd.crank_revs;
          rec.crank_event_time = upd.crank_time;
        end else begin
          st = cpm_pkg::StatusShort;
        end
      end
    end
    rec.status = st;
  end

endmodule

// File: dv/tb_cycling_power_measurement_parser.sv
// Self-checking testbench for the cycling power measurement byte-stream parser.
`timescale 1ns / 1ps

module tb_cycling_power_measurement_parser;

  localparam int TotalBytes = 550;
  localparam int QuietTail  = 60;
  localparam int WatchLimit = 2000;
  localparam int TailCycles = 8;

  // Byte offsets of the optional fields; an end of 0 marks the field absent
  typedef struct {
    int bal_at, bal_end, tq_at, tq_end, wh_at, wh_end, cr_at, cr_end;
  } field_map_t;

  typedef struct {
    cpm_pkg::cpm_in_t beat;
    bit               drain;
  } byte_plan_t;

  logic              clk;
  logic              rst          = 1'b1;
  logic              item_valid   = 1'b0;
  cpm_pkg::cpm_in_t  item         = '0;
  logic              result_stall = 1'b0;
  logic              item_stall;
  logic              result_valid;
  cpm_pkg::cpm_out_t result;

  byte_plan_t          payload_q[$];
  logic [7:0]          pkt_bytes[$];
  cpm_pkg::cpm_out_t   records_due[$];
  cpm_pkg::cpm_state_t parse_st = '0;

  int errors          = 0;
  int planned_bytes   = 0;
  int planned_packets = 0;
  int accepted_bytes  = 0;
  int records_checked = 0;
  int short_records   = 0;
  int idle_cycles     = 0;
  int send_pct        = 0;
  int recv_pct        = 0;
  int send_gap        = 0;
  int recv_gap        = 0;
  int cycle_cnt       = 0;
  bit drain_done      = 1'b0;

  cycling_power_measurement_parser dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Lay out the optional fields in wire order for one flags word
  function automatic field_map_t map_fields(input logic [15:0] f);
    field_map_t m;
    int o;
    m = '{default: 0};
    o = cpm_pkg::HdrLen;
    if (f[cpm_pkg::FlagBal]) begin
      m.bal_at = o; o += cpm_pkg::BalLen; m.bal_end = o;
    end
    if (f[cpm_pkg::FlagTq]) begin
      m.tq_at = o; o += cpm_pkg::TqLen; m.tq_end = o;
    end
    if (f[cpm_pkg::FlagWheel]) begin
      m.wh_at = o; o += cpm_pkg::WheelLen; m.wh_end = o;
    end
    if (f[cpm_pkg::FlagCrank]) begin
      m.cr_at = o; o += cpm_pkg::CrankLen; m.cr_end = o;
    end
    return m;
  endfunction

  function automatic int packet_need(input logic [15:0] f);
    return cpm_pkg::HdrLen
         + (f[cpm_pkg::FlagBal] ? cpm_pkg::BalLen : 0)
         + (f[cpm_pkg::FlagTq] ? cpm_pkg::TqLen : 0)
         + (f[cpm_pkg::FlagWheel] ? cpm_pkg::WheelLen : 0)
         + (f[cpm_pkg::FlagCrank] ? cpm_pkg::CrankLen : 0);
  endfunction

  // Fold one accepted byte into the parse state; on the final byte queue the record
  task automatic parse_byte(input cpm_pkg::cpm_in_t beat);
    cpm_pkg::cpm_out_t rec;
    field_map_t        m;
    int                p;
    int                len;
    logic [7:0]        b;
    b = beat.data_byte;
    p = int'(parse_st.pos);
    if (parse_st.pos < cpm_pkg::PosMax) begin
      if (p < 2) begin
        parse_st.flags[p*8 +: 8] = b;
      end else if (p < cpm_pkg::HdrLen) begin
        parse_st.power[(p-2)*8 +: 8] = b;
      end else begin
        m = map_fields(parse_st.flags);
        if (m.bal_end != 0 && p >= m.bal_at && p < m.bal_end) begin
          parse_st.balance = b;
        end else if (m.tq_end != 0 && p >= m.tq_at && p < m.tq_end) begin
          parse_st.torque[(p-m.tq_at)*8 +: 8] = b;
        end else if (m.wh_end != 0 && p >= m.wh_at && p < m.wh_at + 4) begin
          parse_st.wheel_revs[(p-m.wh_at)*8 +: 8] = b;
        end else if (m.wh_end != 0 && p >= m.wh_at + 4 && p < m.wh_end) begin
          parse_st.wheel_time[(p-m.wh_at-4)*8 +: 8] = b;
        end else if (m.cr_end != 0 && p >= m.cr_at && p < m.cr_at + 2) begin
          parse_st.crank_revs[(p-m.cr_at)*8 +: 8] = b;
        end else if (m.cr_end != 0 && p >= m.cr_at + 2 && p < m.cr_end) begin
          parse_st.crank_time[(p-m.cr_at-2)*8 +: 8] = b;
        end
      end
      parse_st.pos = parse_st.pos + 1'b1;
    end

    if (beat.last_byte) begin
      rec = '0;
      len = p + 1;
      if (len < cpm_pkg::HdrLen) begin
        rec.status = cpm_pkg::StatusShort;
      end else begin
        m = map_fields(parse_st.flags);
        rec.flags_word  = parse_st.flags;
        rec.power_watts = parse_st.power;
        // A field cut short zeroes itself and everything after it
        if (m.bal_end != 0) begin
          if (m.bal_end <= len) rec.pedal_balance = parse_st.balance;
          else rec.status = cpm_pkg::StatusShort;
        end
        if (m.tq_end != 0 && rec.status == cpm_pkg::StatusOk) begin
          if (m.tq_end <= len) rec.torque_total = parse_st.torque;
          else rec.status = cpm_pkg::StatusShort;
        end
        if (m.wh_end != 0 && rec.status == cpm_pkg::StatusOk) begin
          if (m.wh_end <= len) begin
            rec.wheel_revs       = parse_st.wheel_revs;
            rec.wheel_event_time = parse_st.wheel_time;
          end else begin
            rec.status = cpm_pkg::StatusShort;
          end
        end
        if (m.cr_end != 0 && rec.status == cpm_pkg::StatusOk) begin
          if (m.cr_end <= len) begin
            rec.crank_revs       = parse_st.crank_revs;
            rec.crank_event_time = parse_st.crank_time;
          end else begin
            rec.status = cpm_pkg::StatusShort;
          end
        end
      end
      if (rec.status == cpm_pkg::StatusShort) short_records++;
      records_due.push_back(rec);
      parse_st = '0;
    end
  endtask

  // Turn the scratch byte list into planned beats
  task automatic queue_packet(input bit drain);
    byte_plan_t e;
    int i;
    for (i = 0; i < pkt_bytes.size(); i++) begin
      e.beat.data_byte = pkt_bytes[i];
      e.beat.last_byte = (i == pkt_bytes.size() - 1);
      e.drain          = drain && (i == 0);
      payload_q.push_back(e);
    end
    planned_bytes += pkt_bytes.size();
    planned_packets++;
    pkt_bytes.delete();
  endtask

  // Mostly complete packets, some cut short, some shorter than the header, a few overlong
  task automatic random_packet();
    logic [15:0] f;
    int need;
    int len;
    int pick;
    int i;
    f    = 16'($urandom);
    pick = $urandom_range(0, 99);
    need = packet_need(f);
    if (pick < 70) begin
      len = need;
      if ($urandom_range(0, 3) == 0) len += $urandom_range(1, 3);
    end else if (pick < 85) begin
      if (need == cpm_pkg::HdrLen) begin
        f[cpm_pkg::FlagCrank] = 1'b1;
        need = packet_need(f);
      end
      len = $urandom_range(cpm_pkg::HdrLen, need - 1);
    end else if (pick < 95) begin
      len = $urandom_range(1, cpm_pkg::HdrLen - 1);
    end else begin
      len = $urandom_range(28, 40);
    end
    for (i = 0; i < len; i++) begin
      if (i == 0) pkt_bytes.push_back(f[7:0]);
      else if (i == 1) pkt_bytes.push_back(f[15:8]);
      else pkt_bytes.push_back(8'($urandom));
    end
    queue_packet(!drain_done || $urandom_range(0, 24) == 0);
    drain_done = 1'b1;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  // Pick idle rates per stretch of cycles; count cycles with no handshake
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt % 64 == 0) begin
      case ($urandom_range(0, 2))
        0: send_pct <= 0;
        1: send_pct <= 15;
        default: send_pct <= 40;
      endcase
      case ($urandom_range(0, 2))
        0: recv_pct <= 0;
        1: recv_pct <= 15;
        default: recv_pct <= 40;
      endcase
    end
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Driver: present planned beats, hold a stalled beat, insert idle bursts
  always @(posedge clk) begin : driver
    byte_plan_t nxt;
    if (rst) begin
      item_valid <= 1'b0;
      item       <= '0;
    end else begin
      if (item_valid && !item_stall) begin
        parse_byte(item);
        accepted_bytes++;
      end
      if (!item_valid || !item_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          item_valid <= 1'b0;
        end else if (payload_q.size() == 0) begin
          item_valid <= 1'b0;
        end else if (payload_q[0].drain && records_due.size() != 0) begin
          // hold off until every outstanding record has come back
          item_valid <= 1'b0;
        end else if (payload_q.size() >= QuietTail &&
                     $urandom_range(0, 99) < send_pct) begin
          send_gap = $urandom_range(0, 7);
          item_valid <= 1'b0;
        end else begin
          nxt = payload_q.pop_front();
          item       <= nxt.beat;
          item_valid <= 1'b1;
        end
      end
    end
  end

  // Monitor: check each accepted record and drive receiver stall bursts
  always @(posedge clk) begin : monitor
    cpm_pkg::cpm_out_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (records_due.size() == 0) begin
          errors++;
          $display("%0t ns: record with none expected, actual %h", $time, result);
        end else begin
          want = records_due.pop_front();
          records_checked++;
          check_field("status", 32'(want.status), 32'(result.status));
          check_field("flags_word", 32'(want.flags_word), 32'(result.flags_word));
          check_field("power_watts", 32'(want.power_watts), 32'(result.power_watts));
          check_field("pedal_balance", 32'(want.pedal_balance),
                      32'(result.pedal_balance));
          check_field("torque_total", 32'(want.torque_total),
                      32'(result.torque_total));
          check_field("wheel_revs", want.wheel_revs, result.wheel_revs);
          check_field("wheel_event_time", 32'(want.wheel_event_time),
                      32'(result.wheel_event_time));
          check_field("crank_revs", 32'(want.crank_revs), 32'(result.crank_revs));
          check_field("crank_event_time", 32'(want.crank_event_time),
                      32'(result.crank_event_time));
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        result_stall <= 1'b1;
      end else if (payload_q.size() >= QuietTail && $urandom_range(0, 99) < recv_pct) begin
        recv_gap = $urandom_range(0, 7);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  initial begin
    // single byte and three bytes: header never completes
    pkt_bytes = '{8'hA5};
    queue_packet(1'b0);
    pkt_bytes = '{8'h35, 8'h00, 8'hFF};
    queue_packet(1'b0);
    // bare header, most negative power, one trailing byte ignored
    pkt_bytes = '{8'h00, 8'h00, 8'h00, 8'h80, 8'h5A};
    queue_packet(1'b0);
    // every flag bit set, all fields present, largest power
    pkt_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h64, 8'h34, 8'h12,
                  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h80,
                  8'h01, 8'h00, 8'hFF, 8'hFF};
    queue_packet(1'b0);
    // torque cut after its first byte
    pkt_bytes = '{8'h04, 8'h00, 8'h01, 8'h00, 8'hAB};
    queue_packet(1'b0);
    while (planned_bytes < TotalBytes) random_packet();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while ((accepted_bytes < planned_bytes || records_due.size() != 0) &&
           idle_cycles < WatchLimit) begin
      @(posedge clk);
    end
    if (idle_cycles >= WatchLimit) begin
      $display("watchdog: no handshake for %0d cycles", WatchLimit);
      $display("tb_cycling_power_measurement_parser: errors");
    end else begin
      repeat (TailCycles) @(posedge clk);
      if (records_due.size() != 0) begin
        errors++;
        $display("%0t ns: %0d records never arrived", $time, records_due.size());
      end
      $display("sent %0d packets in %0d bytes under random idle and stall bursts",
               planned_packets, accepted_bytes);
      $display("checked %0d records, %0d of them flagged short", records_checked,
               short_records);
      if (errors == 0) begin
        $display("tb_cycling_power_measurement_parser: clean");
      end else begin
        $display("tb_cycling_power_measurement_parser: errors");
      end
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/cpm_pkg.sv
rtl/cpm_parse_step.sv
rtl/cycling_power_measurement_parser.sv
dv/tb_cycling_power_measurement_parser.sv
